### rtl/mtse_pkg.sv
// Shared types and constants for the multitouch slot event encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mtse_pkg;

  // Default slot table depth.
  localparam int SLOTS_DEF = 16;

  // Event types and codes of the multitouch protocol.
  localparam logic [4:0] EV_SYN  = 5'd0;
  localparam logic [4:0] EV_KEY  = 5'd1;
  localparam logic [4:0] EV_ABS  = 5'd3;
  localparam logic [9:0] SYNC_REPORT    = 10'd0;
  localparam logic [9:0] KEY_TOUCH      = 10'd330;
  localparam logic [9:0] MT_SLOT_CODE   = 10'd47;
  localparam logic [9:0] MT_TRACK_CODE  = 10'd57;
  localparam logic [9:0] MT_POS_X_CODE  = 10'd53;
  localparam logic [9:0] MT_POS_Y_CODE  = 10'd54;
  localparam logic [31:0] VALUE_MINUS_ONE   = 32'hFFFF_FFFF;

  // Input operation codes.
  localparam logic OP_CONTACT    = 1'b0;
  localparam logic OP_DISCONNECT = 1'b1;

  // Input word.
  typedef struct packed {
    logic        operation;
    logic [7:0]  source;
    logic [30:0] contact_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        down;
    logic        frame_end;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [4:0]         evt_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
    logic               overflow;
    logic               last;
  } out_word_t;

  // Possible events of one item, in emission order; the value is the mask bit.
  typedef enum logic [2:0] {
    SEL_OVF      = 3'd0,
    SEL_KEY_DOWN = 3'd1,
    SEL_SLOT     = 3'd2,
    SEL_TRACK    = 3'd3,
    SEL_POS_X    = 3'd4,
    SEL_POS_Y    = 3'd5,
    SEL_KEY_UP   = 3'd6,
    SEL_SYNC     = 3'd7
  } event_sel_t;

  localparam int NUM_SEL = 8;

  // Operands held for the events of one item.
  typedef struct packed {
    logic [31:0] slot_value;
    logic [31:0] track_value;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } event_data_t;

  // Lookup status of the slot table for the held item.
  typedef struct packed {
    logic hit;
    logic full;
    logic held_before;
    logic any_after;
  } slot_status_t;

  // Build one event word for a selected event; last is filled in by the caller.
  function automatic out_word_t build_event(event_sel_t sel, event_data_t d);
    out_word_t w;
    w = '0;
    case (sel)
      SEL_OVF: begin
        w.overflow = 1'b1;
      end
      SEL_KEY_DOWN: begin
        w.evt_type    = EV_KEY;
        w.event_code  = KEY_TOUCH;
        w.event_value = 32'sd1;
      end
      SEL_SLOT: begin
        w.evt_type    = EV_ABS;
        w.event_code  = MT_SLOT_CODE;
        w.event_value = d.slot_value;
      end
      SEL_TRACK: begin
        w.evt_type    = EV_ABS;
        w.event_code  = MT_TRACK_CODE;
        w.event_value = d.track_value;
      end
      SEL_POS_X: begin
        w.evt_type    = EV_ABS;
        w.event_code  = MT_POS_X_CODE;
        w.event_value = {16'd0, d.pos_x};
      end
      SEL_POS_Y: begin
        w.evt_type    = EV_ABS;
        w.event_code  = MT_POS_Y_CODE;
        w.event_value = {16'd0, d.pos_y};
      end
      SEL_KEY_UP: begin
        w.evt_type    = EV_KEY;
        w.event_code  = KEY_TOUCH;
        w.event_value = 32'sd0;
      end
      SEL_SYNC: begin
        w.evt_type   = EV_SYN;
        w.event_code = SYNC_REPORT;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/mtse_slot_table.sv
// Slot table: valid bits, source and contact id per slot, parallel match
// and lowest-free search, and the table update of one item. Uses mtse_pkg.
`default_nettype none

module mtse_slot_table #(
  parameter int SLOTS  = mtse_pkg::SLOTS_DEF,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire mtse_pkg::in_word_t item,
  input  wire                     exec,
  output mtse_pkg::slot_status_t  status,
  output logic [SLOT_W-1:0]       slot_idx
);
  import mtse_pkg::*;

  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0]  valid_nxt;
  logic [7:0]        src_r [SLOTS];
  logic [30:0]       cid_r [SLOTS];

  logic [SLOTS-1:0]  hit_vec;
  logic [SLOTS-1:0]  src_vec;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] free_idx;
  logic              hit;
  logic              full;
  logic              alloc;

  // Parallel compare of every slot against the item.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      src_vec[i] = valid_r[i] && (src_r[i] == item.source);
      hit_vec[i] = src_vec[i] && (cid_r[i] == item.contact_id);
    end
  end

  // Lowest matching slot and lowest free slot.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign hit      = |hit_vec;
  assign full     = &valid_r;
  assign slot_idx = hit ? hit_idx : free_idx;
  assign alloc    = (item.operation == OP_CONTACT) && !hit && !full;

  // Valid bits after this item.
  always_comb begin
    valid_nxt = valid_r;
    if (item.operation == OP_DISCONNECT) begin
      valid_nxt = valid_r & ~src_vec;
    end else if (hit || !full) begin
      if (item.down) begin
        valid_nxt[slot_idx] = 1'b1;
      end else begin
        valid_nxt[slot_idx] = 1'b0;
      end
    end
  end

  always_comb begin
    status.hit         = hit;
    status.full        = full;
    status.held_before = |valid_r;
    status.any_after   = |valid_nxt;
  end

  // Valid bits are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (exec) begin
      valid_r <= valid_nxt;
    end
  end

  // Source and contact id are written when a new contact takes a slot.
  always_ff @(posedge clk) begin
    if (exec && alloc) begin
      src_r[free_idx] <= item.source;
      cid_r[free_idx] <= item.contact_id;
    end
  end

endmodule

`default_nettype wire

### rtl/mtse_event_seq.sv
// Event sequencer: holds the pending-event mask of one item and sends its events
// in order via the output register, one word per unstalled cycle. Uses mtse_pkg.
`default_nettype none

module mtse_event_seq (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        load,
  input  wire [7:0]                  load_mask,
  input  wire mtse_pkg::event_data_t load_data,
  output logic                       busy,
  output logic                       out_valid,
  input  wire                        out_ready,
  output mtse_pkg::out_word_t        out_data
);
  import mtse_pkg::*;

  logic [NUM_SEL-1:0] mask_r;
  logic [NUM_SEL-1:0] mask_nxt;
  event_data_t        data_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_word_t          out_word_r;
  out_word_t          out_word_nxt;
  event_sel_t         sel;
  logic [NUM_SEL-1:0] mask_left;
  logic               advance;

  // Lowest pending event.
  always_comb begin
    sel = SEL_SYNC;
    for (int i = NUM_SEL - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = event_sel_t'(3'(i));
      end
    end
  end

  assign mask_left = mask_r & ~(NUM_SEL'(1) << sel);
  assign advance   = (mask_r != '0) && (!out_valid_r || out_ready);
  assign busy      = (mask_r != '0);

  // Next mask, output valid and output word.
  always_comb begin
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    if (advance) begin
      mask_nxt          = mask_left;
      out_valid_nxt     = 1'b1;
      out_word_nxt      = build_event(sel, data_r);
      out_word_nxt.last = (mask_left == '0);
    end
    if (load) begin
      mask_nxt = load_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire

### rtl/multitouch_slot_event_encoder.sv
// Top level of the multitouch slot event encoder.
// Depends on mtse_pkg, mtse_slot_table and mtse_event_seq.
`default_nettype none

// Converts touch contacts into multitouch protocol-B event words using a
// table of SLOTS slots (valid bit, source and contact id each). An accepted
// word waits in the input register until the sequencer is empty; then the
// table is searched and updated and the item's events are queued, and the
// events leave one word per cycle, unless out_ready stalls, through the
// output register, the last one flagged. A contact word produces one to six
// event words; a disconnect word produces none. The next input word is taken
// while the previous item's events drain. Overflow is flagged on a dedicated
// result word when a contact that matches no slot finds every slot taken.
// The valid bits clear at reset; no clearing pass is needed.
module multitouch_slot_event_encoder #(
  parameter int SLOTS = mtse_pkg::SLOTS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire mtse_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output mtse_pkg::out_word_t     out_data
);
  import mtse_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic               item_vld_r;
  logic               item_vld_nxt;
  in_word_t           item_r;
  logic               seq_busy;
  logic               fire;
  slot_status_t       status;
  logic [SLOT_W-1:0]  slot_idx;
  logic [NUM_SEL-1:0] mask;
  event_data_t        data;
  logic               contact;
  logic               ovf;
  logic               ok;

  // Input register: an item is processed once the sequencer is empty.
  assign fire     = item_vld_r && !seq_busy;
  assign in_ready = !item_vld_r || fire;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (fire) begin
      item_vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      item_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  mtse_slot_table #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item_r),
    .exec     (fire),
    .status   (status),
    .slot_idx (slot_idx)
  );

  // Decide which events this item produces.
  assign contact = (item_r.operation == OP_CONTACT);
  assign ovf     = contact && !status.hit && status.full;
  assign ok      = contact && !ovf;

  always_comb begin
    mask               = '0;
    mask[SEL_OVF]      = ovf;
    mask[SEL_KEY_DOWN] = ok && item_r.down && !status.held_before;
    mask[SEL_SLOT]     = ok;
    mask[SEL_TRACK]    = ok && (!item_r.down || !status.hit);
    mask[SEL_POS_X]    = ok && item_r.down;
    mask[SEL_POS_Y]    = ok && item_r.down;
    mask[SEL_KEY_UP]   = ok && status.held_before && !status.any_after;
    mask[SEL_SYNC]     = contact && item_r.frame_end;
  end

  always_comb begin
    data.slot_value  = 32'(slot_idx);
    data.track_value = item_r.down ? {1'b0, item_r.contact_id} : VALUE_MINUS_ONE;
    data.pos_x       = item_r.pos_x;
    data.pos_y       = item_r.pos_y;
  end

  mtse_event_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_mask (mask),
    .load_data (data),
    .busy      (seq_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### test/tb_multitouch_slot_event_encoder.sv
// Self-checking testbench for the multitouch slot event encoder.
// Depends on mtse_pkg and multitouch_slot_event_encoder; it predicts the event words
// from its own copy of the slot table, or takes typed-in ones, and checks each word.
`timescale 1ns / 1ps

module tb_multitouch_slot_event_encoder;
  import mtse_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 75;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  multitouch_slot_event_encoder #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // A 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Shadow copy of the slot table, updated as each input word is accepted.
  logic        tbl_valid   [SLOTS];
  logic [7:0]  tbl_source  [SLOTS];
  logic [30:0] tbl_contact [SLOTS];

  // Events of the word just accepted, and all events still to arrive.
  out_word_t item_events[$];
  out_word_t pending_events[$];

  // Directed words, with the events typed in for the rows that have them.
  in_word_t  dir_items[$];
  int        dir_typed_n[$];
  out_word_t dir_typed[$];

  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  logic steady = 1'b0;

  function automatic out_word_t ev(logic [4:0] etype, logic [9:0] ecode,
                                   logic [31:0] evalue, logic ovf, logic lst);
    out_word_t e;
    e.evt_type    = etype;
    e.event_code  = ecode;
    e.event_value = evalue;
    e.overflow    = ovf;
    e.last        = lst;
    return e;
  endfunction

  function automatic void push_event(logic [4:0] etype, logic [9:0] ecode,
                                     logic [31:0] evalue, logic ovf);
    item_events = {item_events, ev(etype, ecode, evalue, ovf, 1'b0)};
  endfunction

  function automatic void add_typed(out_word_t e);
    dir_typed = {dir_typed, e};
  endfunction

  function automatic logic table_busy();
    int i;
    for (i = 0; i < SLOTS; i++)
      if (tbl_valid[i])
        return 1'b1;
    return 1'b0;
  endfunction

  // Works out the event words of one accepted word and updates the slot table.
  function automatic void encode_contact(in_word_t w);
    int i;
    int slot;
    logic is_new;
    logic held_before;
    logic full;
    out_word_t tail;
    item_events.delete();
    // A disconnect frees every slot of the source and says nothing.
    if (w.operation == OP_DISCONNECT) begin
      for (i = 0; i < SLOTS; i++)
        if (tbl_valid[i] && tbl_source[i] == w.source)
          tbl_valid[i] = 1'b0;
      return;
    end
    slot = -1;
    for (i = 0; i < SLOTS; i++)
      if (slot < 0 && tbl_valid[i] && tbl_source[i] == w.source &&
          tbl_contact[i] == w.contact_id)
        slot = i;
    is_new = (slot < 0);
    held_before = table_busy();
    full = 1'b0;
    if (is_new) begin
      for (i = 0; i < SLOTS; i++)
        if (slot < 0 && !tbl_valid[i])
          slot = i;
      if (slot < 0) begin
        full = 1'b1;
      end else begin
        tbl_valid[slot]   = 1'b1;
        tbl_source[slot]  = w.source;
        tbl_contact[slot] = w.contact_id;
      end
    end
    if (full) begin
      push_event('0, '0, '0, 1'b1);
    end else begin
      if (w.down && !held_before)
        push_event(EV_KEY, KEY_TOUCH, 32'd1, 1'b0);
      push_event(EV_ABS, MT_SLOT_CODE, slot, 1'b0);
      if (w.down) begin
        if (is_new)
          push_event(EV_ABS, MT_TRACK_CODE, {1'b0, w.contact_id}, 1'b0);
        push_event(EV_ABS, MT_POS_X_CODE, {16'd0, w.pos_x}, 1'b0);
        push_event(EV_ABS, MT_POS_Y_CODE, {16'd0, w.pos_y}, 1'b0);
      end else begin
        // The release reports the slot before the entry is erased.
        push_event(EV_ABS, MT_TRACK_CODE, VALUE_MINUS_ONE, 1'b0);
        tbl_valid[slot] = 1'b0;
      end
      if (held_before && !table_busy())
        push_event(EV_KEY, KEY_TOUCH, 32'd0, 1'b0);
    end
    if (w.frame_end)
      push_event(EV_SYN, SYNC_REPORT, 32'd0, 1'b0);
    tail = item_events.pop_back();
    tail.last = 1'b1;
    item_events = {item_events, tail};
  endfunction

  function automatic in_word_t touch(logic [7:0] src, logic [30:0] cid, logic [15:0] x,
                                     logic [15:0] y, logic dn, logic fe);
    in_word_t w;
    w.operation  = OP_CONTACT;
    w.source     = src;
    w.contact_id = cid;
    w.pos_x      = x;
    w.pos_y      = y;
    w.down       = dn;
    w.frame_end  = fe;
    return w;
  endfunction

  function automatic in_word_t unplug(logic [7:0] src);
    in_word_t w;
    w = '0;
    w.operation = OP_DISCONNECT;
    w.source    = src;
    return w;
  endfunction

  function automatic void add_row(in_word_t w, int n_typed);
    dir_items   = {dir_items, w};
    dir_typed_n = {dir_typed_n, n_typed};
  endfunction

  // Picks one occupied slot at random, or -1 when the table is empty.
  function automatic int random_held_slot();
    int i;
    int n;
    int k;
    n = 0;
    for (i = 0; i < SLOTS; i++)
      if (tbl_valid[i])
        n++;
    if (n == 0)
      return -1;
    k = $urandom_range(0, n - 1);
    for (i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i]) begin
        if (k == 0)
          return i;
        k--;
      end
    end
    return -1;
  endfunction

  // Mostly well-formed touch traffic: presses, moves and releases of held
  // contacts, with disconnects, stray releases and raw noise mixed in.
  function automatic in_word_t random_contact_word();
    in_word_t w;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    int kind;
    int held;
    r0 = $urandom;
    r1 = $urandom;
    r2 = $urandom;
    kind = $urandom_range(0, 99);
    held = random_held_slot();
    w.operation  = OP_CONTACT;
    w.source     = (r0[31:30] == 2'b00) ? r0[7:0] : {6'd0, r0[9:8]};
    w.contact_id = r1[31] ? r1[30:0] : {28'd0, r1[2:0]};
    w.pos_x      = r2[15:0];
    w.pos_y      = r2[31:16];
    w.down       = 1'b1;
    w.frame_end  = ($urandom_range(0, 2) == 0);
    if (kind < 8) begin
      w.operation = OP_DISCONNECT;
      if (held >= 0)
        w.source = tbl_source[held];
    end else if (kind < 13) begin
      w = {r0[9:0], r1, r2};
    end else if (kind < 40 && held >= 0) begin
      w.source     = tbl_source[held];
      w.contact_id = tbl_contact[held];
    end else if (kind < 62 && held >= 0) begin
      w.source     = tbl_source[held];
      w.contact_id = tbl_contact[held];
      w.down       = 1'b0;
    end else if (kind < 68) begin
      w.down = 1'b0;
    end
    return w;
  endfunction

  // Sends one word, in bursts of random length with random gaps unless steady is set.
  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (!steady) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  // The receiver alternates between modes with no stalls and with stalls of
  // varying length.
  int stall_left = 0;
  int rx_mode = 1;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (rx_mode != 0 && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(1, rx_mode * 3);
    end
    if (cycles % 150 == 149)
      rx_mode = $urandom_range(0, 3);
  end

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  // Compares each result word with the oldest expected one.
  out_word_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: word with none expected, expected nothing, actual %p",
                 $time, out_data);
      end else begin
        want = pending_events.pop_front();
        check_field("evt_type", {27'd0, want.evt_type}, {27'd0, out_data.evt_type});
        check_field("event_code", {22'd0, want.event_code}, {22'd0, out_data.event_code});
        check_field("event_value", want.event_value, out_data.event_value);
        check_field("overflow", {31'd0, want.overflow}, {31'd0, out_data.overflow});
        check_field("last", {31'd0, want.last}, {31'd0, out_data.last});
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int row;
    int k;
    logic [3:0] kk;
    in_word_t w;

    for (k = 0; k < SLOTS; k++)
      tbl_valid[k] = 1'b0;

    // First contact after reset: key down, slot, id, position and sync.
    add_row(touch(8'h00, 31'd0, 16'h0000, 16'h0000, 1'b1, 1'b1), 6);
    add_typed(ev(EV_KEY, KEY_TOUCH, 32'd1, 1'b0, 1'b0));
    add_typed(ev(EV_ABS, MT_SLOT_CODE, 32'd0, 1'b0, 1'b0));
    add_typed(ev(EV_ABS, MT_TRACK_CODE, 32'd0, 1'b0, 1'b0));
    add_typed(ev(EV_ABS, MT_POS_X_CODE, 32'd0, 1'b0, 1'b0));
    add_typed(ev(EV_ABS, MT_POS_Y_CODE, 32'd0, 1'b0, 1'b0));
    add_typed(ev(EV_SYN, SYNC_REPORT, 32'd0, 1'b0, 1'b1));
    // Move of a held contact to the far corner.
    add_row(touch(8'h00, 31'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0), 0);
    // Largest source and id, then the same id from another source.
    add_row(touch(8'hFF, 31'h7FFF_FFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1), 0);
    add_row(touch(8'hFF, 31'd0, 16'h0000, 16'hFFFF, 1'b1, 1'b0), 0);
    // Fill the rest of the table.
    for (k = 0; k < SLOTS - 3; k++) begin
      kk = k[3:0];
      add_row(touch(8'h01, {27'd0, kk}, {kk, 12'h3A5}, {12'h5C3, kk}, 1'b1,
                    k == SLOTS - 4), 0);
    end
    // Table full: a new press and a stray release both overflow.
    add_row(touch(8'h02, 31'd99, 16'd1234, 16'd5678, 1'b1, 1'b1), 2);
    add_typed(ev('0, '0, '0, 1'b1, 1'b0));
    add_typed(ev(EV_SYN, SYNC_REPORT, 32'd0, 1'b0, 1'b1));
    add_row(touch(8'h05, 31'd123, 16'h0000, 16'h0000, 1'b0, 1'b0), 1);
    add_typed(ev('0, '0, '0, 1'b1, 1'b1));
    // Release of a held contact, then a stray release while others are held.
    add_row(touch(8'h00, 31'd0, 16'h0000, 16'h0000, 1'b0, 1'b0), 0);
    add_row(touch(8'h05, 31'd123, 16'h0000, 16'h0000, 1'b0, 1'b1), 0);
    // Disconnects empty the table without a key-up event.
    add_row(unplug(8'h01), 0);
    add_row(unplug(8'hFF), 0);
    // Stray release on an empty table, then a full press and release cycle.
    add_row(touch(8'h06, 31'd42, 16'h0000, 16'h0000, 1'b0, 1'b1), 0);
    add_row(touch(8'h07, 31'd1, 16'd100, 16'd200, 1'b1, 1'b0), 0);
    add_row(touch(8'h07, 31'd1, 16'h0000, 16'h0000, 1'b0, 1'b1), 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    for (row = 0; row < dir_items.size(); row++) begin
      send_word(dir_items[row]);
      encode_contact(dir_items[row]);
      if (dir_typed_n[row] == 0) begin
        pending_events = {pending_events, item_events};
      end else begin
        repeat (dir_typed_n[row])
          pending_events = {pending_events, dir_typed.pop_front()};
      end
    end

    // Random part, with one stretch of back-to-back words and one pause
    // that lets every pending event drain.
    for (row = 0; row < RANDOM_WORDS; row++) begin
      steady = (row >= 20 && row < 40);
      if (row == 50) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
          @(posedge clk);
      end
      w = random_contact_word();
      send_word(w);
      encode_contact(w);
      pending_events = {pending_events, item_events};
    end
    in_valid <= 1'b0;

    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### multitouch_slot_event_encoder.f
rtl/mtse_pkg.sv
rtl/mtse_slot_table.sv
rtl/mtse_event_seq.sv
rtl/multitouch_slot_event_encoder.sv
test/tb_multitouch_slot_event_encoder.sv
